// ===== rtl/cfd_pkg.sv =====
package cfd_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LENGTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_TYPE = 2'd3;

   localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd1000;
   localparam logic [7:0]  MIN_LENGTH_RESET    = 8'd50;
   localparam logic [7:0]  MAX_LENGTH_RESET    = 8'd150;
   localparam logic [7:0]  EXPECTED_TYPE_RESET = 8'd26;

   localparam logic [7:0] HDR_FIRST  = 8'hFF;
   localparam logic [7:0] HDR_SECOND = 8'hFB;
   localparam logic [7:0] TYPE_LIMIT = 8'hF1;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_GOT_FF  = 3'd1;
   localparam logic [2:0] PH_GOT_FB  = 3'd2;
   localparam logic [2:0] PH_GOT_TYP = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CHECK   = 3'd5;

   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_GOOD     = 2'd1;
   localparam logic [1:0] KIND_BAD_SUM  = 2'd2;
   localparam logic [1:0] KIND_BAD_TYPE = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [7:0] frame_type;
      logic [7:0] frame_length;
   } cfd_result_type;

endpackage

// ===== rtl/cfd_if.sv =====
interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic [7:0] frame_type;
   logic [7:0] frame_length;

   modport source (output valid, output kind, output data_byte, output byte_index,
                   output frame_type, output frame_length, input ready);
   modport sink (input valid, input kind, input data_byte, input byte_index,
                 input frame_type, input frame_length, output ready);
endinterface

// ===== rtl/cfd_in_stage.sv =====
module cfd_in_stage (
   input  logic       clock,
   input  logic       reset,
   cfd_req_if.sink    req_ch,
   input  logic       advance,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_ch.rx_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

// ===== rtl/cfd_parse.sv =====
module cfd_parse
   import cfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   step,
   input  logic [7:0]             in_byte,
   output logic                   produce,
   output cfd_result_type         result
);

   logic [15:0] timeout_ff;
   logic [7:0]  min_len_ff;
   logic [7:0]  max_len_ff;
   logic [7:0]  exp_type_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  taken_ff, taken_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] idle_ff, idle_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  len_ff, len_in;

   logic [16:0] next_count;
   logic        timed_out;
   logic [2:0]  phase_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_LIMIT_RESET;
         min_len_ff  <= MIN_LENGTH_RESET;
         max_len_ff  <= MAX_LENGTH_RESET;
         exp_type_ff <= EXPECTED_TYPE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMEOUT_LIMIT: begin
               timeout_ff <= csr_wdata[15:0];
            end
            CSR_MIN_LENGTH: begin
               min_len_ff <= csr_wdata[7:0];
            end
            CSR_MAX_LENGTH: begin
               max_len_ff <= csr_wdata[7:0];
            end
            CSR_EXPECTED_TYPE: begin
               exp_type_ff <= csr_wdata[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      next_count = {1'b0, idle_ff} + 17'd1;
      timed_out  = next_count > {1'b0, timeout_ff};
      phase_eff  = timed_out ? PH_IDLE : phase_ff;
      idle_in    = timed_out ? 16'd0 : next_count[15:0];

      phase_in = phase_eff;
      left_in  = left_ff;
      taken_in = taken_ff;
      sum_in   = sum_ff;
      type_in  = type_ff;
      len_in   = len_ff;

      produce             = 1'b0;
      result.kind         = KIND_PAYLOAD;
      result.data_byte    = in_byte;
      result.byte_index   = taken_ff;
      result.frame_type   = type_ff;
      result.frame_length = len_ff;

      if (phase_eff == PH_IDLE && in_byte == HDR_FIRST) begin
         phase_in = PH_GOT_FF;
         sum_in   = HDR_FIRST;
         idle_in  = 16'd0;
      end else if (phase_eff == PH_GOT_FF && in_byte == HDR_SECOND) begin
         phase_in = PH_GOT_FB;
         sum_in   = sum_ff + in_byte;
         idle_in  = 16'd0;
      end else if (phase_eff == PH_GOT_FF && in_byte == HDR_FIRST) begin
         sum_in  = HDR_FIRST;
         idle_in = 16'd0;
      end else if (phase_eff == PH_GOT_FB && in_byte != 8'd0 && in_byte < TYPE_LIMIT) begin
         phase_in = PH_GOT_TYP;
         type_in  = in_byte;
         sum_in   = sum_ff + in_byte;
         idle_in  = 16'd0;
      end else if (phase_eff == PH_GOT_TYP) begin
         idle_in = 16'd0;
         if (in_byte < min_len_ff || in_byte > max_len_ff) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in = PH_PAYLOAD;
            len_in   = in_byte;
            left_in  = in_byte;
            taken_in = 8'd0;
            sum_in   = sum_ff + in_byte;
         end
      end else if (phase_eff == PH_PAYLOAD && left_ff != 8'd0) begin
         left_in  = left_ff - 8'd1;
         produce  = 1'b1;
         taken_in = taken_ff + 8'd1;
         sum_in   = sum_ff + in_byte;
         if (left_ff == 8'd1) begin
            phase_in = PH_CHECK;
            idle_in  = 16'd0;
         end
      end else if (phase_eff == PH_CHECK) begin
         phase_in = PH_IDLE;
         idle_in  = 16'd0;
         produce  = 1'b1;
         if (sum_ff != in_byte) begin
            result.kind = KIND_BAD_SUM;
         end else if (type_ff == exp_type_ff) begin
            result.kind = KIND_GOOD;
         end else begin
            result.kind = KIND_BAD_TYPE;
         end
      end else begin
         if (in_byte == HDR_FIRST) begin
            phase_in = PH_GOT_FF;
            sum_in   = HDR_FIRST;
         end else begin
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         left_ff  <= 8'd0;
         taken_ff <= 8'd0;
         sum_ff   <= 8'd0;
         idle_ff  <= 16'd0;
         type_ff  <= 8'd0;
         len_ff   <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         taken_ff <= taken_in;
         sum_ff   <= sum_in;
         idle_ff  <= idle_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
      end
   end

   // Inside a payload, bytes taken plus bytes still due always equal the declared length.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> (taken_ff + left_ff) == len_ff)
      else $error("payload counters disagree with the declared length");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CHECK |-> left_ff == 8'd0)
      else $error("checksum phase reached with payload bytes still due");

   assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_CHECK |=> phase_ff == PH_IDLE)
      else $error("parser did not return to idle after the checksum byte");

   assert property (@(posedge clock) disable iff (reset)
      step && produce && result.kind != KIND_PAYLOAD |=> phase_ff == PH_IDLE)
      else $error("frame status issued without ending the frame");

endmodule

// ===== rtl/cfd_out_stage.sv =====
module cfd_out_stage
   import cfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  cfd_result_type result,
   output logic           out_free,
   cfd_rsp_if.source      rsp_ch
);

   logic           valid_ff;
   logic           valid_in;
   cfd_result_type data_ff;

   assign out_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.kind         = data_ff.kind;
   assign rsp_ch.data_byte    = data_ff.data_byte;
   assign rsp_ch.byte_index   = data_ff.byte_index;
   assign rsp_ch.frame_type   = data_ff.frame_type;
   assign rsp_ch.frame_length = data_ff.frame_length;

endmodule

// ===== rtl/checksummed_frame_deframer.sv =====
// A byte is held in the input register and its result in the output register feeding rsp_ch.
// Throughput: one byte per cycle while results are taken; a byte that produces a result waits
// in the input register as long as an earlier result is still pending on the response channel.
// Bytes that produce no result still pass through the input register without waiting on rsp_ch.
// Reset is synchronous and active high: it empties both stages, clears the parser state
// and loads the configuration registers with their default values.
module checksummed_frame_deframer
   import cfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   cfd_req_if.sink                req_ch,
   cfd_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic           in_valid;
   logic [7:0]     in_byte;
   logic           produce;
   logic           out_free;
   logic           step;
   cfd_result_type result;

   assign step = in_valid && (!produce || out_free);

   cfd_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .advance  (step),
      .in_valid (in_valid),
      .in_byte  (in_byte)
   );

   cfd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .in_byte   (in_byte),
      .produce   (produce),
      .result    (result)
   );

   cfd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (step && produce),
      .result   (result),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule
